// File: rtl/core/rri_pkg.sv
package rri_pkg;

  localparam int T_FRAC        = 16;
  localparam int T_BITS        = 32;
  localparam int MIN_DIST_BITS = 20;
  localparam int IDX_BITS      = 3;

  localparam logic [IDX_BITS-1:0] REG_CORNER   = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_EDGE_A   = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_EDGE_B   = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_NORMAL   = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_A_LEN_SQ = 3'd4;
  localparam logic [IDX_BITS-1:0] REG_B_LEN_SQ = 3'd5;
  localparam logic [IDX_BITS-1:0] REG_MIN_DIST = 3'd6;

  localparam logic [MIN_DIST_BITS-1:0] MIN_DIST_RESET = 20'd1;

endpackage

// File: rtl/core/rri_if.sv
interface rri_in_if #(parameter int COORD_BITS = 20);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] origin_x;
  logic signed [COORD_BITS-1:0] origin_y;
  logic signed [COORD_BITS-1:0] origin_z;
  logic signed [COORD_BITS-1:0] dir_x;
  logic signed [COORD_BITS-1:0] dir_y;
  logic signed [COORD_BITS-1:0] dir_z;
  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  output ready);
endinterface

interface rri_out_if #(parameter int COORD_BITS = 20);
  logic                           valid;
  logic                           ready;
  logic                           hit_flag;
  logic [rri_pkg::T_BITS-1:0]     hit_distance;
  logic signed [COORD_BITS-1:0]   hit_x;
  logic signed [COORD_BITS-1:0]   hit_y;
  logic signed [COORD_BITS-1:0]   hit_z;
  modport source (output valid, hit_flag, hit_distance, hit_x, hit_y, hit_z, input ready);
  modport sink   (input valid, hit_flag, hit_distance, hit_x, hit_y, hit_z, output ready);
endinterface

interface rri_cfg_if #(parameter int COORD_BITS = 20);
  logic                           valid;
  logic                           ready;
  logic [rri_pkg::IDX_BITS-1:0]   index;
  logic [3*COORD_BITS-1:0]        data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/rri_front.sv
module rri_front #(parameter int C = 20) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [3*C-1:0]   org,
  input  logic [3*C-1:0]   dir,
  input  logic [3*C-1:0]   corner,
  input  logic [3*C-1:0]   normal,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2*C-1:0]   rem,
  output logic [2*C-1:0]   den,
  output logic [rri_pkg::T_BITS-1:0] bits,
  output logic [3*C-1:0]   org_o,
  output logic [3*C-1:0]   dir_o,
  output logic             kill
);

  localparam int NS = 4;

  logic [NS-1:0] v_r;
  logic [NS:0]   adv;

  logic [3*C-1:0] org_r [NS];
  logic [3*C-1:0] dir_r [NS];

  logic signed [C:0]     diff_r [3];
  logic signed [2*C:0]   pn_r   [3];
  logic signed [2*C-1:0] dn_r   [3];

  logic [2*C:0]   num_mag_r;
  logic [2*C-1:0] den_mag_r;
  logic           kill3_r;

  logic [2*C-1:0] rem_r;
  logic [2*C-1:0] den_r;
  logic [rri_pkg::T_BITS-1:0] bits_r;
  logic           kill_r;

  logic signed [2*C+2:0] num_sum;
  logic signed [2*C+1:0] den_sum;
  logic signed [2*C+2:0] num_neg;
  logic signed [2*C+1:0] den_neg;
  logic                  num_pos;
  logic                  ovf;

  always_comb begin
    adv[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_comb begin
    num_sum = '0;
    den_sum = '0;
    for (int i = 0; i < 3; i++) begin
      num_sum = num_sum + (2*C+3)'(pn_r[i]);
      den_sum = den_sum + (2*C+2)'(dn_r[i]);
    end
    num_neg = -num_sum;
    den_neg = -den_sum;
    num_pos = den_sum[2*C+1] ? num_sum[2*C+2] : (!num_sum[2*C+2] && (num_sum != '0));
  end

  assign ovf = {{rri_pkg::T_FRAC{1'b0}}, num_mag_r} >= {1'b0, den_mag_r, {rri_pkg::T_FRAC{1'b0}}};

  always_ff @(posedge clk) begin
    // stage 1: corner minus origin
    if (adv[0]) begin
      org_r[0] <= org;
      dir_r[0] <= dir;
      for (int i = 0; i < 3; i++) begin
        diff_r[i] <= $signed({corner[i*C+C-1], corner[i*C +: C]})
                   - $signed({org[i*C+C-1], org[i*C +: C]});
      end
    end
    // stage 2: products with the normal
    if (adv[1]) begin
      org_r[1] <= org_r[0];
      dir_r[1] <= dir_r[0];
      for (int i = 0; i < 3; i++) begin
        pn_r[i] <= diff_r[i] * $signed(normal[i*C +: C]);
        dn_r[i] <= $signed(dir_r[0][i*C +: C]) * $signed(normal[i*C +: C]);
      end
    end
    // stage 3: dot sums, sign fold so the denominator is positive
    if (adv[2]) begin
      org_r[2]  <= org_r[1];
      dir_r[2]  <= dir_r[1];
      num_mag_r <= den_sum[2*C+1] ? num_neg[2*C:0] : num_sum[2*C:0];
      den_mag_r <= den_sum[2*C+1] ? den_neg[2*C-1:0] : den_sum[2*C-1:0];
      kill3_r   <= (den_sum == '0) || !num_pos;
    end
    // stage 4: range check of the quotient, divider seed
    if (adv[3]) begin
      org_r[3] <= org_r[2];
      dir_r[3] <= dir_r[2];
      kill_r   <= kill3_r || ovf;
      rem_r    <= {{(rri_pkg::T_FRAC-1){1'b0}}, num_mag_r[2*C:rri_pkg::T_FRAC]};
      bits_r   <= {num_mag_r[rri_pkg::T_FRAC-1:0], {rri_pkg::T_FRAC{1'b0}}};
      den_r    <= den_mag_r;
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v_r[NS-1];
  assign rem       = rem_r;
  assign den       = den_r;
  assign bits      = bits_r;
  assign org_o     = org_r[NS-1];
  assign dir_o     = dir_r[NS-1];
  assign kill      = kill_r;

endmodule

// File: rtl/core/rri_div_stage.sv
module rri_div_stage #(
  parameter int C  = 20,
  parameter int SW = 121
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [2*C-1:0]             rem_i,
  input  logic [rri_pkg::T_BITS-1:0] bits_i,
  input  logic [2*C-1:0]             den_i,
  input  logic [SW-1:0]              side_i,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2*C-1:0]             rem_o,
  output logic [rri_pkg::T_BITS-1:0] bits_o,
  output logic [2*C-1:0]             den_o,
  output logic [SW-1:0]              side_o
);

  logic                       v_r;
  logic [2*C-1:0]             rem_r;
  logic [rri_pkg::T_BITS-1:0] bits_r;
  logic [2*C-1:0]             den_r;
  logic [SW-1:0]              side_r;

  logic [2*C:0] rem2;
  logic [2*C:0] diff;
  logic         ge;

  assign in_ready = !v_r || out_ready;

  // one quotient bit: bring down the next dividend bit, subtract if it fits
  assign rem2 = {rem_i, bits_i[rri_pkg::T_BITS-1]};
  assign ge   = rem2 >= {1'b0, den_i};
  assign diff = rem2 - {1'b0, den_i};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      rem_r  <= ge ? diff[2*C-1:0] : rem2[2*C-1:0];
      bits_r <= {bits_i[rri_pkg::T_BITS-2:0], ge};
      den_r  <= den_i;
      side_r <= side_i;
    end
  end

  assign out_valid = v_r;
  assign rem_o     = rem_r;
  assign bits_o    = bits_r;
  assign den_o     = den_r;
  assign side_o    = side_r;

endmodule

// File: rtl/core/rri_back.sv
module rri_back #(parameter int C = 20) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rri_pkg::T_BITS-1:0]        t,
  input  logic [3*C-1:0]                    org,
  input  logic [3*C-1:0]                    dir,
  input  logic                              kill,
  input  logic [3*C-1:0]                    corner,
  input  logic [3*C-1:0]                    edge_a,
  input  logic [3*C-1:0]                    edge_b,
  input  logic [2*C-1:0]                    a_len_sq,
  input  logic [2*C-1:0]                    b_len_sq,
  input  logic [rri_pkg::MIN_DIST_BITS-1:0] min_dist,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              hit,
  output logic [rri_pkg::T_BITS-1:0]        hit_dist,
  output logic [3*C-1:0]                    hit_pt
);

  localparam int NS = 4;
  localparam int TB = rri_pkg::T_BITS;
  localparam int HW = C + 18;
  localparam int OW = C + 19;
  localparam int PW = 2*C + 19;
  localparam int SUMW = 2*C + 21;
  localparam logic signed [HW-1:0] SAT_HI = HW'((64'd1 << (C-1)) - 64'd1);
  localparam logic signed [HW-1:0] SAT_LO = -SAT_HI - HW'(1);

  logic [NS-1:0] v_r;
  logic [NS:0]   adv;

  logic signed [TB+C:0]  tp_r [3];
  logic [TB-1:0]         t1_r, t2_r, t3_r;
  logic [3*C-1:0]        org1_r;
  logic                  kill1_r, kill2_r, kill3_r;

  logic signed [HW-1:0]  h_r   [3];
  logic signed [OW-1:0]  off_r [3];
  logic signed [HW-1:0]  h3_r  [3];
  logic signed [PW-1:0]  pa_r  [3];
  logic signed [PW-1:0]  pb_r  [3];

  logic                  hit_r;
  logic [TB-1:0]         dist_r;
  logic [3*C-1:0]        pt_r;

  logic signed [HW-1:0]  h_nxt   [3];
  logic signed [OW-1:0]  off_nxt [3];
  logic signed [SUMW-1:0] da, db;
  logic                  hit_nxt;
  logic [3*C-1:0]        pt_nxt;

  function automatic logic [C-1:0] sat(input logic signed [HW-1:0] v);
    logic signed [HW-1:0] c;
    begin
      c = v;
      if (v > SAT_HI) c = SAT_HI;
      if (v < SAT_LO) c = SAT_LO;
      sat = c[C-1:0];
    end
  endfunction

  always_comb begin
    adv[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // hit point (floor of t*d by arithmetic shift) and offset from the corner
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      h_nxt[i] = HW'($signed(org1_r[i*C +: C]))
               + HW'($signed(tp_r[i][TB+C:rri_pkg::T_FRAC]));
      off_nxt[i] = OW'(h_nxt[i]) - OW'($signed(corner[i*C +: C]));
    end
  end

  always_comb begin
    da = '0;
    db = '0;
    for (int i = 0; i < 3; i++) begin
      da = da + SUMW'(pa_r[i]);
      db = db + SUMW'(pb_r[i]);
    end
    hit_nxt = !kill3_r
           && !da[SUMW-1] && (da <= $signed({21'b0, a_len_sq}))
           && !db[SUMW-1] && (db <= $signed({21'b0, b_len_sq}));
    for (int i = 0; i < 3; i++) begin
      pt_nxt[i*C +: C] = hit_nxt ? sat(h3_r[i]) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      t1_r    <= t;
      org1_r  <= org;
      kill1_r <= kill || (t <= {{(TB-rri_pkg::MIN_DIST_BITS){1'b0}}, min_dist});
      for (int i = 0; i < 3; i++) begin
        tp_r[i] <= $signed({1'b0, t}) * $signed(dir[i*C +: C]);
      end
    end
    if (adv[1]) begin
      t2_r    <= t1_r;
      kill2_r <= kill1_r;
      for (int i = 0; i < 3; i++) begin
        h_r[i]   <= h_nxt[i];
        off_r[i] <= off_nxt[i];
      end
    end
    // edge projections
    if (adv[2]) begin
      t3_r    <= t2_r;
      kill3_r <= kill2_r;
      for (int i = 0; i < 3; i++) begin
        h3_r[i] <= h_r[i];
        pa_r[i] <= off_r[i] * $signed(edge_a[i*C +: C]);
        pb_r[i] <= off_r[i] * $signed(edge_b[i*C +: C]);
      end
    end
    if (adv[3]) begin
      hit_r  <= hit_nxt;
      dist_r <= hit_nxt ? t3_r : '0;
      pt_r   <= pt_nxt;
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v_r[NS-1];
  assign hit       = hit_r;
  assign hit_dist  = dist_r;
  assign hit_pt    = pt_r;

endmodule

// File: rtl/core/ray_rectangle_intersect.sv
// channel   dir  word
// in_ch     in   ray origin_x/y/z, dir_x/y/z
// out_ch    out  hit_flag, hit_distance, hit_x/y/z
// cfg_ch    in   index, data (register write, always ready)
//
// one ray per cycle sustained while out_ch takes every word; from accept to result a ray passes:
// 4 dot-product stages, 32 restoring divider stages (one quotient bit each),
// 4 hit-point and edge-test stages, the last one the output register.
// each stage holds its word while the next is full, so bubbles close up on a stall.
// rst_n is synchronous; it clears the valid bits and sets the registers to defaults.
module ray_rectangle_intersect #(
  parameter int COORD_BITS = 20
) (
  input logic        clk,
  input logic        rst_n,
  rri_in_if.sink     in_ch,
  rri_out_if.source  out_ch,
  rri_cfg_if.sink    cfg_ch
);

  localparam int C  = COORD_BITS;
  localparam int SW = 6*C + 1;
  localparam int ND = rri_pkg::T_BITS;

  logic [3*C-1:0] corner_r, edge_a_r, edge_b_r, normal_r;
  logic [2*C-1:0] a_len_r, b_len_r;
  logic [rri_pkg::MIN_DIST_BITS-1:0] min_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corner_r   <= '0;
      edge_a_r   <= '0;
      edge_b_r   <= '0;
      normal_r   <= '0;
      a_len_r    <= '0;
      b_len_r    <= '0;
      min_dist_r <= rri_pkg::MIN_DIST_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        rri_pkg::REG_CORNER:   corner_r   <= cfg_ch.data;
        rri_pkg::REG_EDGE_A:   edge_a_r   <= cfg_ch.data;
        rri_pkg::REG_EDGE_B:   edge_b_r   <= cfg_ch.data;
        rri_pkg::REG_NORMAL:   normal_r   <= cfg_ch.data;
        rri_pkg::REG_A_LEN_SQ: a_len_r    <= cfg_ch.data[2*C-1:0];
        rri_pkg::REG_B_LEN_SQ: b_len_r    <= cfg_ch.data[2*C-1:0];
        rri_pkg::REG_MIN_DIST: min_dist_r <= cfg_ch.data[rri_pkg::MIN_DIST_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ch.ready = 1'b1;

  logic [3*C-1:0] org_in, dir_in;
  assign org_in = {in_ch.origin_z, in_ch.origin_y, in_ch.origin_x};
  assign dir_in = {in_ch.dir_z, in_ch.dir_y, in_ch.dir_x};

  logic                div_v   [ND+1];
  logic                div_rdy [ND+1];
  logic [2*C-1:0]      div_rem [ND+1];
  logic [ND-1:0]       div_bit [ND+1];
  logic [2*C-1:0]      div_den [ND+1];
  logic [SW-1:0]       div_sd  [ND+1];
  logic [3*C-1:0]      f_org, f_dir;
  logic                f_kill;

  rri_front #(.C(C)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .org       (org_in),
    .dir       (dir_in),
    .corner    (corner_r),
    .normal    (normal_r),
    .out_valid (div_v[0]),
    .out_ready (div_rdy[0]),
    .rem       (div_rem[0]),
    .den       (div_den[0]),
    .bits      (div_bit[0]),
    .org_o     (f_org),
    .dir_o     (f_dir),
    .kill      (f_kill)
  );

  assign div_sd[0] = {f_kill, f_dir, f_org};

  for (genvar k = 0; k < ND; k++) begin : g_div
    rri_div_stage #(.C(C), .SW(SW)) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (div_v[k]),
      .in_ready  (div_rdy[k]),
      .rem_i     (div_rem[k]),
      .bits_i    (div_bit[k]),
      .den_i     (div_den[k]),
      .side_i    (div_sd[k]),
      .out_valid (div_v[k+1]),
      .out_ready (div_rdy[k+1]),
      .rem_o     (div_rem[k+1]),
      .bits_o    (div_bit[k+1]),
      .den_o     (div_den[k+1]),
      .side_o    (div_sd[k+1])
    );
  end

  logic [3*C-1:0] hit_pt;

  rri_back #(.C(C)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (div_v[ND]),
    .in_ready  (div_rdy[ND]),
    .t         (div_bit[ND]),
    .org       (div_sd[ND][3*C-1:0]),
    .dir       (div_sd[ND][6*C-1:3*C]),
    .kill      (div_sd[ND][6*C]),
    .corner    (corner_r),
    .edge_a    (edge_a_r),
    .edge_b    (edge_b_r),
    .a_len_sq  (a_len_r),
    .b_len_sq  (b_len_r),
    .min_dist  (min_dist_r),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .hit       (out_ch.hit_flag),
    .hit_dist  (out_ch.hit_distance),
    .hit_pt    (hit_pt)
  );

  assign out_ch.hit_x = hit_pt[C-1:0];
  assign out_ch.hit_y = hit_pt[2*C-1:C];
  assign out_ch.hit_z = hit_pt[3*C-1:2*C];

  // an empty output stage means every stage can move, so a ray is taken
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready) else $error("input stalled with empty output stage");

  a_miss_zero_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.hit_flag |-> out_ch.hit_distance == '0)
    else $error("miss word carries a distance");

  a_miss_zero_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.hit_flag |-> hit_pt == '0)
    else $error("miss word carries a hit point");

  a_hit_beyond_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.hit_flag |->
      out_ch.hit_distance > {{(ND-rri_pkg::MIN_DIST_BITS){1'b0}}, min_dist_r})
    else $error("hit at or below minimum distance");

endmodule

// File: bench/tb_ray_rectangle_intersect.sv
`timescale 1ns / 100ps

module tb_ray_rectangle_intersect;

  localparam int CB = 20;
  localparam int ONE = 1024;
  localparam int LATENCY = 40;
  localparam longint CYCLE_LIMIT = 400000;
  localparam logic [rri_pkg::IDX_BITS-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic signed [CB-1:0] ox, oy, oz, dx, dy, dz;
  } ray_t;

  typedef struct packed {
    logic                         flag;
    logic [rri_pkg::T_BITS-1:0]   distance;
    logic signed [CB-1:0]         x, y, z;
  } hit_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rri_in_if  #(.COORD_BITS(CB)) in_ch ();
  rri_out_if #(.COORD_BITS(CB)) out_ch ();
  rri_cfg_if #(.COORD_BITS(CB)) cfg_ch ();

  ray_rectangle_intersect #(.COORD_BITS(CB)) DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow copy of the rectangle registers
  logic [3*CB-1:0]        rect_corner, rect_a, rect_b, rect_normal;
  logic [2*CB-1:0]        rect_a_len, rect_b_len;
  logic [rri_pkg::MIN_DIST_BITS-1:0] rect_min_dist;

  ray_t ray_q[$];
  hit_t hit_q[$];
  int   rays_sent, hits_seen, results_seen, errors;
  longint cycles;
  int   hold_left;
  bit   hold_done;

  function automatic longint vcomp(logic [3*CB-1:0] v, int i);
    logic signed [CB-1:0] c;
    c = v[i*CB +: CB];
    return longint'(c);
  endfunction

  function automatic logic signed [CB-1:0] clip(longint v);
    longint hi, lo;
    hi = (longint'(1) <<< (CB-1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[CB-1:0];
  endfunction

  function automatic logic [3*CB-1:0] pack3(longint x, longint y, longint z);
    return {z[CB-1:0], y[CB-1:0], x[CB-1:0]};
  endfunction

  function automatic hit_t trace_ray(ray_t r);
    longint o[3], d[3], p[3], h[3];
    longint num, den, t, da, db, off;
    hit_t res;
    res = '0;
    o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
    d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
    num = 0; den = 0; da = 0; db = 0;
    for (int i = 0; i < 3; i++) begin
      p[i] = vcomp(rect_corner, i);
      num += (p[i] - o[i]) * vcomp(rect_normal, i);
      den += d[i] * vcomp(rect_normal, i);
    end
    if (den == 0) return res;
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    t = (num * (longint'(1) <<< rri_pkg::T_FRAC)) / den;
    if (t <= longint'(rect_min_dist) || t > 64'sd4294967295) return res;
    for (int i = 0; i < 3; i++) begin
      h[i] = o[i] + ((t * d[i]) >>> rri_pkg::T_FRAC);
      off = h[i] - p[i];
      da += off * vcomp(rect_a, i);
      db += off * vcomp(rect_b, i);
    end
    if (da < 0 || da > longint'(rect_a_len)) return res;
    if (db < 0 || db > longint'(rect_b_len)) return res;
    res.flag = 1'b1;
    res.distance = t[rri_pkg::T_BITS-1:0];
    res.x = clip(h[0]);
    res.y = clip(h[1]);
    res.z = clip(h[2]);
    return res;
  endfunction

  // ray driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        hit_q.push_back(trace_ray({in_ch.origin_x, in_ch.origin_y, in_ch.origin_z,
                                   in_ch.dir_x, in_ch.dir_y, in_ch.dir_z}));
        rays_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (ray_q.size() > 0 &&
            ((rays_sent >= 700 && rays_sent < 1000) || $urandom_range(99) >= 37)) begin
          ray_t r;
          r = ray_q.pop_front();
          in_ch.valid    <= 1'b1;
          in_ch.origin_x <= r.ox;
          in_ch.origin_y <= r.oy;
          in_ch.origin_z <= r.oz;
          in_ch.dir_x    <= r.dx;
          in_ch.dir_y    <= r.dy;
          in_ch.dir_z    <= r.dz;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (hit_q.size() == 0) begin
          $error("unexpected result word: hit_flag=%0b", out_ch.hit_flag);
          errors++;
        end else begin
          hit_t e;
          e = hit_q.pop_front();
          if (out_ch.hit_flag) hits_seen++;
          if (out_ch.hit_flag !== e.flag) begin
            $error("hit_flag expected %0b actual %0b", e.flag, out_ch.hit_flag);
            errors++;
          end
          if (out_ch.hit_distance !== e.distance) begin
            $error("hit_distance expected %0h actual %0h", e.distance,
                   out_ch.hit_distance);
            errors++;
          end
          if (out_ch.hit_x !== e.x) begin
            $error("hit_x expected %0d actual %0d", e.x, out_ch.hit_x);
            errors++;
          end
          if (out_ch.hit_y !== e.y) begin
            $error("hit_y expected %0d actual %0d", e.y, out_ch.hit_y);
            errors++;
          end
          if (out_ch.hit_z !== e.z) begin
            $error("hit_z expected %0d actual %0d", e.z, out_ch.hit_z);
            errors++;
          end
        end
      end
      // one long hold-off so the pipeline fills and backs up the input
      if (!hold_done && rays_sent >= 200) begin
        hold_done <= 1'b1;
        hold_left <= 300;
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= (rays_sent >= 700 && rays_sent < 1000) || $urandom_range(99) >= 37;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_ray_rectangle_intersect failed");
      $finish;
    end
  end

  task automatic write_reg(logic [rri_pkg::IDX_BITS-1:0] idx, logic [3*CB-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      rri_pkg::REG_CORNER:   rect_corner   = val;
      rri_pkg::REG_EDGE_A:   rect_a        = val;
      rri_pkg::REG_EDGE_B:   rect_b        = val;
      rri_pkg::REG_NORMAL:   rect_normal   = val;
      rri_pkg::REG_A_LEN_SQ: rect_a_len    = val[2*CB-1:0];
      rri_pkg::REG_B_LEN_SQ: rect_b_len    = val[2*CB-1:0];
      rri_pkg::REG_MIN_DIST: rect_min_dist = val[rri_pkg::MIN_DIST_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic drain;
    while (ray_q.size() > 0 || in_ch.valid || hit_q.size() > 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic set_rect(longint px, longint py, longint pz, longint ax, longint ay,
                          longint az, longint bx, longint by, longint bz,
                          longint nx, longint ny, longint nz, longint mind);
    write_reg(rri_pkg::REG_CORNER, pack3(px, py, pz));
    write_reg(rri_pkg::REG_EDGE_A, pack3(ax, ay, az));
    write_reg(rri_pkg::REG_EDGE_B, pack3(bx, by, bz));
    write_reg(rri_pkg::REG_NORMAL, pack3(nx, ny, nz));
    write_reg(rri_pkg::REG_A_LEN_SQ, (3*CB)'(ax*ax + ay*ay + az*az));
    write_reg(rri_pkg::REG_B_LEN_SQ, (3*CB)'(bx*bx + by*by + bz*bz));
    write_reg(rri_pkg::REG_MIN_DIST, (3*CB)'(mind));
  endtask

  function automatic longint fit(longint v);
    return clip(v);
  endfunction

  function automatic ray_t any_ray();
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    return raw[6*CB-1:0];
  endfunction

  // ray aimed at a point inside (or just outside) the current rectangle
  function automatic ray_t aimed_ray(int reach);
    longint tgt[3], o[3], d[3];
    longint u, v;
    int mode;
    ray_t r;
    u = longint'($urandom_range(1100)) - 38;
    v = longint'($urandom_range(1100)) - 38;
    mode = $urandom_range(3);
    for (int i = 0; i < 3; i++) begin
      tgt[i] = vcomp(rect_corner, i) + (u * vcomp(rect_a, i) + v * vcomp(rect_b, i)) / ONE;
      o[i] = fit(tgt[i] + longint'($urandom_range(2*reach)) - reach);
      d[i] = tgt[i] - o[i];
      if (mode == 1) d[i] = d[i] * 2;
      else if (mode == 2) d[i] = d[i] >>> 1;
      else if (mode == 3) d[i] = -d[i];
      d[i] = fit(d[i]);
    end
    r = {o[0][CB-1:0], o[1][CB-1:0], o[2][CB-1:0], d[0][CB-1:0], d[1][CB-1:0], d[2][CB-1:0]};
    return r;
  endfunction

  task automatic random_rays(int count, int reach);
    for (int k = 0; k < count; k++)
      ray_q.push_back(($urandom_range(99) < 80) ? aimed_ray(reach) : any_ray());
  endtask

  localparam logic signed [CB-1:0] MAXC = 20'sh7FFFF;
  localparam logic signed [CB-1:0] MINC = -20'sh80000;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.origin_x = '0; in_ch.origin_y = '0; in_ch.origin_z = '0;
    in_ch.dir_x = '0; in_ch.dir_y = '0; in_ch.dir_z = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    rect_corner = '0; rect_a = '0; rect_b = '0; rect_normal = '0;
    rect_a_len = '0; rect_b_len = '0; rect_min_dist = rri_pkg::MIN_DIST_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: zero normal, every ray misses
    ray_q.push_back({MAXC, MAXC, MAXC, MAXC, MAXC, MAXC});
    ray_q.push_back({MINC, MINC, MINC, MINC, MINC, MINC});
    drain();

    // flat square in z = 0
    set_rect(-10*ONE, -10*ONE, 0, 20*ONE, 0, 0, 0, 20*ONE, 0, 0, 0, ONE, 1);
    ray_q.push_back({20'sd0, 20'sd0, 20'sd5120, 20'sd0, 20'sd0, -20'sd1024});   // straight hit
    ray_q.push_back({20'sd0, 20'sd0, 20'sd5120, 20'sd1024, 20'sd0, 20'sd0});    // parallel
    ray_q.push_back({20'sd0, 20'sd0, 20'sd5120, 20'sd0, 20'sd0, 20'sd1024});    // behind
    ray_q.push_back({20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0, -20'sd1024});      // t zero
    ray_q.push_back({20'sd0, 20'sd0, MAXC, 20'sd0, 20'sd0, -20'sd1});           // t overflow
    ray_q.push_back({20'sd0, 20'sd0, 20'sd1, 20'sd0, 20'sd0, MINC});            // tiny t
    ray_q.push_back({-20'sd10240, -20'sd10240, 20'sd2048, 20'sd0, 20'sd0, -20'sd1024}); // corner
    ray_q.push_back({20'sd10240, 20'sd10240, 20'sd2048, 20'sd0, 20'sd0, -20'sd1024});   // far corner
    ray_q.push_back({20'sd10241, 20'sd0, 20'sd2048, 20'sd0, 20'sd0, -20'sd1024});   // past edge a
    ray_q.push_back({20'sd0, -20'sd10241, 20'sd2048, 20'sd0, 20'sd0, -20'sd1024});  // before edge b
    ray_q.push_back({MAXC, MINC, MAXC, MINC, MAXC, MINC});
    ray_q.push_back({MINC, MAXC, MINC, MAXC, MINC, MAXC});
    random_rays(450, 60*ONE);
    drain();

    // tilted parallelogram, half-unit minimum distance
    set_rect(-8*ONE, -6*ONE, 3*ONE, 16*ONE, 0, 4*ONE, 4*ONE, 12*ONE, 0,
             -ONE, 0, 4*ONE, 20'h08000);
    random_rays(450, 100*ONE);
    drain();

    // rectangle near the top of the coordinate range: hit points saturate
    set_rect(500*ONE, 0, 0, 20*ONE, 0, 0, 0, 8*ONE, 0, 0, 0, ONE, 0);
    random_rays(300, 10*ONE);
    drain();

    // largest minimum distance
    write_reg(rri_pkg::REG_MIN_DIST, 60'hFFFFF);
    set_rect(-10*ONE, -10*ONE, 0, 20*ONE, 0, 0, 0, 20*ONE, 0, 0, 0, ONE, 20'hFFFFF);
    random_rays(100, 200*ONE);
    drain();

    // all-ones geometry registers, zero minimum distance and a write to an unused index
    write_reg(rri_pkg::REG_CORNER, '1);
    write_reg(rri_pkg::REG_EDGE_A, '1);
    write_reg(rri_pkg::REG_EDGE_B, '1);
    write_reg(rri_pkg::REG_NORMAL, '1);
    write_reg(rri_pkg::REG_A_LEN_SQ, '1);
    write_reg(rri_pkg::REG_B_LEN_SQ, '1);
    write_reg(rri_pkg::REG_MIN_DIST, 60'h0);
    write_reg(REG_UNUSED, '1);
    for (int k = 0; k < 150; k++) ray_q.push_back(any_ray());
    drain();

    $display("rays sent: %0d, results checked: %0d, hits: %0d", rays_sent, results_seen,
             hits_seen);
    $display("covered reset, flat, tilted, saturating and all-ones rectangles");
    if (errors == 0) begin
      $display("tb_ray_rectangle_intersect passed");
    end else begin
      $display("tb_ray_rectangle_intersect failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/rri_pkg.sv
rtl/core/rri_if.sv
rtl/core/rri_front.sv
rtl/core/rri_div_stage.sv
rtl/core/rri_back.sv
rtl/core/ray_rectangle_intersect.sv
bench/tb_ray_rectangle_intersect.sv
